@@ hw/rtl/tcw_pkg.sv @@
package tcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // Cell word and character widths
  localparam int CELL_W = 16;
  localparam int CHAR_W = 8;

  // Fixed character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'h20;

  // Cursor row after reset, clamped to the last row on short screens
  localparam int RESET_LINE = 19;

  // Reset value of the blank attribute register
  localparam logic [CELL_W-1:0] BLANK_COLOR_RST = 16'h0700;

  // Item actions
  typedef enum logic [1:0] {
    ACT_PRINT    = 2'd0,
    ACT_PRINT_AT = 2'd1,
    ACT_READ     = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

endpackage

@@ hw/rtl/tcw_cell_mem.sv @@
module tcw_cell_mem #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
  parameter int WIDTH = tcw_pkg::CELL_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  import tcw_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/text_console_writer.sv @@
// Text console writer: cursor-driven character store over a COLUMNS x ROWS cell memory.
// A word passes the item registers, EXEC (then READ for a cell read), the result holding
// register and the output register. A new word is taken only in IDLE with the holding
// register free. A print that scrolls first runs the copy sweep, one cell per cycle.
// Reset (rst, synchronous): cursor to column 0, row 19 (last row if fewer rows), blank
// attribute 0x0700; the cell memory is not cleared.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [39:0]               s_tdata,   // character[7:0], color[23:8],
                                               // pos_col[30:24], pos_row[35:31], zero pad
  input  logic [1:0]                s_tuser,   // action[1:0]
  // result stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [55:0]               m_tdata,   // wrote_cell[0], cell_index[11:1],
                                               // cell_word[27:12], scrolled[28],
                                               // cursor_col[35:29], cursor_row[40:36],
                                               // debug_valid[41], debug_byte[49:42], zero pad
  // blank attribute register write
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tcw_pkg::CELL_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CELLS   = COLUMNS * ROWS;
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int ROW_RST = (RESET_LINE < ROWS) ? RESET_LINE : ROWS - 1;
  localparam int COPY_N  = CELLS - COLUMNS;

  typedef struct packed {
    logic [7:0]  debug_byte;
    logic        debug_valid;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
    logic [15:0] cell_word;
    logic [10:0] cell_index;
    logic        wrote_cell;
  } res_t;

  typedef enum logic [2:0] {
    IDLE,
    EXEC,
    READ,
    SCROLL,
    SCROLL_END
  } state_t;

  state_t state;

  // registered item
  action_t            act;
  logic [CHAR_W-1:0]  ch;
  logic [CELL_W-1:0]  color;
  logic [COL_W-1:0]   pcol;
  logic [ROW_W-1:0]   prow;

  // cursor and blank attribute
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [CELL_W-1:0]  blank_color;

  // result holding register and output register
  res_t               res;
  logic               res_valid;
  logic               res_move;
  res_t               out_q;

  // scroll sweep
  logic [ADDR_W-1:0]  sweep;
  logic               sw_valid;
  logic [ADDR_W-1:0]  sw_addr;
  logic               sw_fill;

  // memory ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  // input unpack with position saturation
  logic [6:0]         in_col;
  logic [4:0]         in_row;
  logic [COL_W-1:0]   in_col_sat;
  logic [ROW_W-1:0]   in_row_sat;

  // execute-stage decode
  logic [COL_W-1:0]   base_col;
  logic [ROW_W-1:0]   base_row;
  logic [ADDR_W-1:0]  idx;
  logic               is_print;
  logic               is_nl;
  logic               exec_we;
  logic               wrap;
  logic               last_row;
  logic               do_scroll;
  logic [COL_W-1:0]   col_next;
  logic [ROW_W-1:0]   row_next;
  logic [CELL_W-1:0]  print_word;
  logic [CELL_W-1:0]  blank_word;
  res_t               exec_res;

  assign cfg_ready = 1'b1;
  assign res_move  = res_valid && (!m_tvalid || m_tready);
  assign s_tready  = (state == IDLE) && (!res_valid || res_move);
  assign m_tdata   = {6'd0, out_q};

  // saturate the requested position
  always_comb begin
    in_col = s_tdata[30:24];
    in_row = s_tdata[35:31];
    if (32'(in_col) >= COLUMNS) begin
      in_col_sat = COL_W'(COLUMNS - 1);
    end else begin
      in_col_sat = COL_W'(in_col);
    end
    if (32'(in_row) >= ROWS) begin
      in_row_sat = ROW_W'(ROWS - 1);
    end else begin
      in_row_sat = ROW_W'(in_row);
    end
  end

  // decode of the registered item
  always_comb begin
    is_print = (act == ACT_PRINT) || (act == ACT_PRINT_AT);
    is_nl    = (ch == NEWLINE_CHAR);
    base_col = (act == ACT_PRINT) ? cur_col : pcol;
    base_row = (act == ACT_PRINT) ? cur_row : prow;
    idx      = ADDR_W'(32'(base_row) * COLUMNS + 32'(base_col));
    exec_we  = (state == EXEC) && is_print && !is_nl;
    wrap     = is_nl || (32'(base_col) == COLUMNS - 1);
    last_row = (32'(base_row) == ROWS - 1);
    do_scroll = is_print && wrap && last_row;
    print_word = color | {{(CELL_W-CHAR_W){1'b0}}, ch};
    blank_word = blank_color | {{(CELL_W-CHAR_W){1'b0}}, SPACE_CHAR};

    // cursor after the item; only a print at cursor moves it
    col_next = cur_col;
    row_next = cur_row;
    if (act == ACT_PRINT) begin
      if (wrap) begin
        col_next = '0;
        row_next = last_row ? ROW_W'(ROWS - 1) : ROW_W'(32'(base_row) + 1);
      end else begin
        col_next = COL_W'(32'(base_col) + 1);
      end
    end

    exec_res             = '0;
    exec_res.cursor_col  = 7'(col_next);
    exec_res.cursor_row  = 5'(row_next);
    exec_res.scrolled    = do_scroll;
    exec_res.debug_valid = is_print;
    exec_res.debug_byte  = is_print ? ch : '0;
    if (is_print && !is_nl) begin
      exec_res.wrote_cell = 1'b1;
      exec_res.cell_index = 11'(idx);
      exec_res.cell_word  = print_word;
    end else if (act == ACT_READ) begin
      exec_res.cell_index = 11'(idx);
    end
  end

  // memory port selection: execute access or scroll sweep
  always_comb begin
    mem_we    = exec_we || sw_valid;
    mem_waddr = sw_valid ? sw_addr : idx;
    mem_wdata = sw_valid ? (sw_fill ? blank_word : mem_rdata) : print_word;
    mem_re    = ((state == EXEC) && (act == ACT_READ)) ||
                ((state == SCROLL) && (32'(sweep) < COPY_N));
    mem_raddr = (state == SCROLL) ? ADDR_W'(32'(sweep) + COLUMNS) : idx;
  end

  tcw_cell_mem #(
    .DEPTH (CELLS),
    .WIDTH (CELL_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer, cursor, result and output registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      cur_col     <= '0;
      cur_row     <= ROW_W'(ROW_RST);
      blank_color <= BLANK_COLOR_RST;
      res_valid   <= 1'b0;
      m_tvalid    <= 1'b0;
      sw_valid    <= 1'b0;
      sweep       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        blank_color <= cfg_data;
      end

      // output register takes the held result when free
      if (res_move) begin
        out_q    <= res;
        m_tvalid <= 1'b1;
        res_valid <= 1'b0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // the sweep write is registered from each sweep step and follows it in the next cycle
      sw_valid <= (state == SCROLL);

      unique case (state)
        IDLE: begin
          if (s_tvalid && s_tready) begin
            act   <= action_t'(s_tuser);
            ch    <= s_tdata[7:0];
            color <= s_tdata[23:8];
            pcol  <= in_col_sat;
            prow  <= in_row_sat;
            state <= EXEC;
          end
        end
        EXEC: begin
          res     <= exec_res;
          cur_col <= col_next;
          cur_row <= row_next;
          if (act == ACT_READ) begin
            state <= READ;
          end else if (do_scroll) begin
            sweep <= '0;
            state <= SCROLL;
          end else begin
            res_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        READ: begin
          res.cell_word <= mem_rdata;
          res_valid     <= 1'b1;
          state         <= IDLE;
        end
        SCROLL: begin
          // write in the cycle after the read of the row below
          sw_addr  <= sweep;
          sw_fill  <= (32'(sweep) >= COPY_N);
          if (32'(sweep) == CELLS - 1) begin
            state <= SCROLL_END;
          end else begin
            sweep <= ADDR_W'(32'(sweep) + 1);
          end
        end
        SCROLL_END: begin
          res_valid <= 1'b1;
          state     <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // the sweep never competes with an execute-stage write
  assert property (@(posedge clk) disable iff (rst) sw_valid |-> !exec_we)
    else $error("sweep write collides with print write");

  // cursor stays on the screen
  assert property (@(posedge clk) disable iff (rst)
    (32'(cur_col) < COLUMNS) && (32'(cur_row) < ROWS))
    else $error("cursor off screen");

  // a held result is not dropped
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_move) |=> res_valid)
    else $error("held result lost");

  // an accepted word always goes to execute next
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == EXEC))
    else $error("accepted word not executed");

  // a result is produced only with an empty holding register at accept
  assert property (@(posedge clk) disable iff (rst)
    (state == EXEC) |-> !res_valid)
    else $error("result register busy during execute");
`endif

endmodule
